// ===== hw/rtl/dmcs_pkg.sv =====
// shared types, constants and helpers for the debounced multi-click mode switch
package dmcs_pkg;

  // field widths
  localparam int unsigned TimeW  = 32;
  localparam int unsigned MsW    = 16;
  localparam int unsigned ClickW = 4;
  localparam int unsigned NoteW  = 3;
  localparam int unsigned ModeW  = 2;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;

  // click counter saturates here
  localparam logic [ClickW-1:0] MaxClicks = ClickW'(6);

  // reset values
  localparam logic [MsW-1:0]    DebounceRst  = MsW'(50);
  localparam logic [MsW-1:0]    PauseRst     = MsW'(1000);
  localparam logic [ClickW-1:0] ClicksOffRst  = ClickW'(2);
  localparam logic [ClickW-1:0] ClicksOnRst   = ClickW'(3);
  localparam logic [ClickW-1:0] ClicksAutoRst = ClickW'(4);
  localparam logic [ClickW-1:0] ClicksTempRst = ClickW'(5);
  // minus 1000 modulo 2^32
  localparam logic [TimeW-1:0]  TimeRst = 32'hFFFF_FC18;

  typedef enum logic [NoteW-1:0] {
    NOTE_NONE          = 3'd0,
    NOTE_ENTER_MENU    = 3'd1,
    NOTE_PRESS_KEY     = 3'd2,
    NOTE_RESTART_TIMER = 3'd3,
    NOTE_MODE          = 3'd4
  } note_e;

  typedef enum logic [ModeW-1:0] {
    MODE_OFF  = 2'd0,
    MODE_ON   = 2'd1,
    MODE_AUTO = 2'd2,
    MODE_TEMP = 2'd3
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DEBOUNCE    = 3'd0,
    CFG_PAUSE       = 3'd1,
    CFG_CLICKS_OFF  = 3'd2,
    CFG_CLICKS_ON   = 3'd3,
    CFG_CLICKS_AUTO = 3'd4,
    CFG_CLICKS_TEMP = 3'd5
  } cfg_idx_e;

  // signed (now - then) below an unsigned limit
  function automatic logic elapsed_below(input logic [TimeW-1:0] now,
                                         input logic [TimeW-1:0] then_t,
                                         input logic [MsW-1:0]   limit);
    logic [TimeW-1:0] diff;
    diff = now - then_t;
    return diff[TimeW-1] || (diff < {{(TimeW-MsW){1'b0}}, limit});
  endfunction

endpackage

// ===== hw/rtl/dmcs_in_if.sv =====
// input sample channel: timestamp, raw pin level, menu flag, partner level
interface dmcs_in_if
  import dmcs_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [TimeW-1:0] now_ms;
  logic             raw_level;
  logic             menu_active;
  logic             partner_clean;

  modport source (output valid, now_ms, raw_level, menu_active, partner_clean, input ready);
  modport sink   (input valid, now_ms, raw_level, menu_active, partner_clean, output ready);
endinterface

// ===== hw/rtl/dmcs_out_if.sv =====
// result channel: note, mode, clean level, idle flag
interface dmcs_out_if
  import dmcs_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [NoteW-1:0] note;
  logic [ModeW-1:0] mode;
  logic             clean_out;
  logic             is_idle;

  modport source (output valid, note, mode, clean_out, is_idle, input ready);
  modport sink   (input valid, note, mode, clean_out, is_idle, output ready);
endinterface

// ===== hw/rtl/dmcs_cfg_if.sv =====
// register write channel: index and data
interface dmcs_cfg_if
  import dmcs_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/debounced_multi_click_mode_switch_top.sv =====
// Debounced multi-click mode switch: takes one switch sample per beat and returns one
// result per beat. A sample is captured in an input register, the debounce / click
// state is updated from that register by a single pass of compare and subtract logic
// once the result side can accept it, and the result lands in an output register; a
// new sample is taken every cycle while the result side keeps up. The state loop (two
// 32-bit time subtractions, their range checks and the click select) is one pass of
// logic, which sets the rate at one sample per clock. Register writes take effect at
// once and are meant to arrive only while no sample is in flight.
module debounced_multi_click_mode_switch_top
  import dmcs_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  dmcs_in_if.sink    in_i,
  dmcs_out_if.source out_o,
  dmcs_cfg_if.sink   cfg_i
);

  // configuration registers
  logic [MsW-1:0]    debounce_q, pause_q;
  logic [ClickW-1:0] clk_off_q, clk_on_q, clk_auto_q, clk_temp_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= DebounceRst;
      pause_q    <= PauseRst;
      clk_off_q  <= ClicksOffRst;
      clk_on_q   <= ClicksOnRst;
      clk_auto_q <= ClicksAutoRst;
      clk_temp_q <= ClicksTempRst;
    end else if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.index))
        CFG_DEBOUNCE:    debounce_q <= cfg_i.data;
        CFG_PAUSE:       pause_q    <= cfg_i.data;
        CFG_CLICKS_OFF:  clk_off_q  <= cfg_i.data[ClickW-1:0];
        CFG_CLICKS_ON:   clk_on_q   <= cfg_i.data[ClickW-1:0];
        CFG_CLICKS_AUTO: clk_auto_q <= cfg_i.data[ClickW-1:0];
        CFG_CLICKS_TEMP: clk_temp_q <= cfg_i.data[ClickW-1:0];
        default: ;
      endcase
    end
  end

  // pipeline handshake
  logic in_valid_q, out_valid_q;
  logic advance, fire;

  assign advance    = !out_valid_q || out_o.ready;
  assign fire       = in_valid_q && advance;
  assign in_i.ready = !in_valid_q || advance;

  // input register
  logic [TimeW-1:0] now_q;
  logic lvl_q, menu_q, partner_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      now_q     <= in_i.now_ms;
      lvl_q     <= in_i.raw_level;
      menu_q    <= in_i.menu_active;
      partner_q <= in_i.partner_clean;
    end
  end

  // switch state
  logic phys_q, phys_d, clean_q, clean_d, chatter_q, chatter_d, menu_seen_q, menu_seen_d;
  mode_e mode_q, mode_d;
  logic [ClickW-1:0] count_q, count_d;
  logic [TimeW-1:0]  chat_time_q, chat_time_d, tog_time_q, tog_time_d;
  note_e note_d;

  logic below_deb_tog, below_pause_tog, below_deb_chat;
  assign below_deb_tog   = elapsed_below(now_q, tog_time_q, debounce_q);
  assign below_pause_tog = elapsed_below(now_q, tog_time_q, pause_q);
  assign below_deb_chat  = elapsed_below(now_q, chat_time_q, debounce_q);

  // one pass of the debounce and click logic
  always_comb begin
    logic do_clean;
    logic sel_ok;
    mode_e sel;
    phys_d      = phys_q;
    clean_d     = clean_q;
    chatter_d   = chatter_q;
    menu_seen_d = menu_seen_q;
    mode_d      = mode_q;
    count_d     = count_q;
    chat_time_d = chat_time_q;
    tog_time_d  = tog_time_q;
    note_d      = NOTE_NONE;
    do_clean    = 1'b0;
    sel_ok      = 1'b1;
    sel         = MODE_OFF;

    if (phys_q == lvl_q) begin
      if (chatter_q) begin
        // chatter ends after a quiet window
        if (!below_deb_chat) begin
          chatter_d = 1'b0;
          if (clean_q != lvl_q) begin
            tog_time_d = chat_time_q;
            do_clean   = 1'b1;
          end
        end
      end else if (!lvl_q && !menu_q && !below_pause_tog && (count_q != '0)) begin
        // long pause: the click count picks a mode
        if (count_q == clk_off_q) begin
          sel = MODE_OFF;
        end else if (count_q == clk_on_q) begin
          sel = MODE_ON;
        end else if (count_q == clk_auto_q) begin
          sel = MODE_AUTO;
        end else if (count_q == clk_temp_q) begin
          sel = MODE_TEMP;
        end else begin
          sel_ok = 1'b0;
        end
        count_d = '0;
        if (sel_ok && (mode_q != sel)) begin
          mode_d = sel;
          note_d = NOTE_MODE;
        end
      end
    end else if (below_deb_tog) begin
      // toggle too close to the last one: chatter
      chatter_d   = 1'b1;
      chat_time_d = now_q;
      phys_d      = lvl_q;
    end else begin
      // clean toggle
      chatter_d  = 1'b0;
      tog_time_d = now_q;
      phys_d     = lvl_q;
      if (lvl_q && !below_pause_tog) begin
        count_d = '0;
      end
      do_clean = 1'b1;
    end

    // clean level change
    if (do_clean) begin
      clean_d = lvl_q;
      if (lvl_q) begin
        if (partner_q) begin
          note_d = NOTE_ENTER_MENU;
        end else if (menu_q) begin
          note_d = NOTE_PRESS_KEY;
        end else begin
          note_d = NOTE_RESTART_TIMER;
        end
      end else if (menu_seen_q || menu_q) begin
        count_d = '0;
      end else if (count_d < MaxClicks) begin
        count_d = count_d + ClickW'(1);
      end
      menu_seen_d = menu_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phys_q      <= 1'b0;
      clean_q     <= 1'b0;
      chatter_q   <= 1'b0;
      menu_seen_q <= 1'b0;
      mode_q      <= MODE_AUTO;
      count_q     <= '0;
      chat_time_q <= TimeRst;
      tog_time_q  <= TimeRst;
    end else if (fire) begin
      phys_q      <= phys_d;
      clean_q     <= clean_d;
      chatter_q   <= chatter_d;
      menu_seen_q <= menu_seen_d;
      mode_q      <= mode_d;
      count_q     <= count_d;
      chat_time_q <= chat_time_d;
      tog_time_q  <= tog_time_d;
    end
  end

  // result register
  note_e note_q;
  mode_e res_mode_q;
  logic  res_clean_q, res_idle_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      note_q      <= note_d;
      res_mode_q  <= mode_d;
      res_clean_q <= clean_d;
      res_idle_q  <= !(clean_d || phys_d || (count_d != '0));
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.note      = note_q;
  assign out_o.mode      = res_mode_q;
  assign out_o.clean_out = res_clean_q;
  assign out_o.is_idle   = res_idle_q;

endmodule

// ===== hw/rtl/dmcs_checker.sv =====
// port-level checks for the mode switch, bound to the top level
module dmcs_checker
  import dmcs_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             out_valid,
  input logic             out_ready,
  input logic [NoteW-1:0] out_note,
  input logic [ModeW-1:0] out_mode,
  input logic             out_clean,
  input logic             out_idle
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_note) && $stable(out_mode)
      && $stable(out_clean) && $stable(out_idle))
    else $error("result beat changed while stalled");

  // menu, key and timeout notes come only with the clean level high
  a_press_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && (out_note == NOTE_ENTER_MENU || out_note == NOTE_PRESS_KEY
      || out_note == NOTE_RESTART_TIMER) |-> out_clean)
    else $error("press note without clean high");

  // a mode change ends a click sequence with the switch released and count cleared
  a_mode_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_note == NOTE_MODE |-> out_idle && !out_clean)
    else $error("mode change while not idle");

  // idle implies a released clean level
  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_idle |-> !out_clean)
    else $error("idle with clean level high");

endmodule

bind debounced_multi_click_mode_switch_top dmcs_checker u_dmcs_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .out_note  (out_o.note),
  .out_mode  (out_o.mode),
  .out_clean (out_o.clean_out),
  .out_idle  (out_o.is_idle)
);
